>>> hdl/stt_pkg.sv
// Shared types, token codes and lookup functions for the source text tokenizer.
package stt_pkg;

  localparam int STT_FIFO_DEPTH = 4;
  localparam int PREFIX_CHARS   = 8;
  localparam int PUNCT_COUNT    = 18;

  localparam logic [4:0] KIND_IDENT       = 5'd0;
  localparam logic [4:0] KIND_RESERVED    = 5'd1;
  localparam logic [4:0] KIND_PUNCT_BASE  = 5'd2;
  localparam logic [4:0] KIND_UNKNOWN     = 5'd20;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] = '{
    8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B, 8'h2C, 8'h2E,
    8'h2D, 8'h2B, 8'h2F, 8'h2A, 8'h21, 8'h3D, 8'h3C, 8'h3E, 8'h22
  };

  // keyword prefixes, first character in the low byte
  localparam logic [8*PREFIX_CHARS-1:0] KW_FUNCTION = 64'h6E6F_6974_636E_7566;
  localparam logic [8*PREFIX_CHARS-1:0] KW_RET      = 64'h0000_0000_0074_6572;
  localparam logic [8*PREFIX_CHARS-1:0] KW_I64      = 64'h0000_0000_0034_3669;
  localparam logic [7:0] KW_FUNCTION_LEN = 8'd8;
  localparam logic [7:0] KW_SHORT_LEN    = 8'd3;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  bad_char;
    logic [31:0] line;
    logic [15:0] column;
    logic [31:0] offset;
    logic [7:0]  length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     first;
    token_t     second;
  } res_pair_t;

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] kind;
    kind = KIND_UNKNOWN;
    for (int i = 0; i < PUNCT_COUNT; i++) begin
      if (c == PUNCT_CHARS[i]) kind = KIND_PUNCT_BASE + 5'(i);
    end
    return kind;
  endfunction

  function automatic logic is_reserved(input logic [8*PREFIX_CHARS-1:0] prefix,
                                       input logic [7:0] len);
    return ((len == KW_FUNCTION_LEN) && (prefix == KW_FUNCTION)) ||
           ((len == KW_SHORT_LEN) && (prefix == KW_RET)) ||
           ((len == KW_SHORT_LEN) && (prefix == KW_I64));
  endfunction

endpackage

>>> hdl/source_text_tokenizer.sv
// Top level of the source text tokenizer: byte stream in, token stream out.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall   | char_code, end_of_text
//  out_    | output    | out_valid/out_stall | token_kind, bad_char, token_line,
//          |           |                     | token_column, token_offset,
//          |           |                     | token_length, last_of_run
//
// One byte is taken per cycle while in_stall is low; its tokens enter the result queue at the
// accepting edge and, if the queue was empty, the first shows on out_ in the following cycle.
// A byte that closes a word and is itself a token yields two words, drained one per cycle when not stalled.
// in_stall rises when the queue holds more than FIFO_DEPTH-2 words.
// Reset is synchronous: position restarts at line 1, column 1, offset 0, queue empties.
// The byte flagged end_of_text flushes an open word and restarts the position.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int FIFO_DEPTH = STT_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [7:0]  out_bad_char,
  output logic [31:0] out_token_line,
  output logic [15:0] out_token_column,
  output logic [31:0] out_token_offset,
  output logic [7:0]  out_token_length,
  output logic        out_last_of_run
);

  logic      accept;
  logic      full;
  res_pair_t res;
  token_t    head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  stt_lex u_lex (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .char_code   (in_char_code),
    .end_of_text (in_end_of_text),
    .res         (res)
  );

  stt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign out_token_kind   = head.kind;
  assign out_bad_char     = head.bad_char;
  assign out_token_line   = head.line;
  assign out_token_column = head.column;
  assign out_token_offset = head.offset;
  assign out_token_length = head.length;
  assign out_last_of_run  = head.last;

endmodule

>>> hdl/stt_lex.sv
// Byte classifier, word tracker and position counters; forms up to two tokens per byte.
module stt_lex import stt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic [7:0] char_code,
  input  logic      end_of_text,
  output res_pair_t res
);

  logic                      in_word_r;
  logic [8*PREFIX_CHARS-1:0] prefix_r, prefix_nxt;
  logic [7:0]                len_r, len_nxt;
  logic [31:0]               wline_r, wline_nxt;
  logic [15:0]               wcol_r, wcol_nxt;
  logic [31:0]               woff_r, woff_nxt;
  logic [31:0]               line_r, line_nxt;
  logic [15:0]               col_r, col_nxt;
  logic [31:0]               off_r, off_nxt;
  logic                      in_word_nxt;

  logic letter, digit, alnum, space;
  logic w_cont, start, emit_old, emit_eot, emit_word, single;
  logic [4:0] pkind;
  token_t word_tok, char_tok;

  always_comb begin
    letter = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
             ((char_code >= 8'h61) && (char_code <= 8'h7A));
    digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
    alnum  = letter || digit;
    space  = (char_code == CH_NEWLINE) || (char_code == CH_SPACE) ||
             (char_code == CH_RETURN) || (char_code == CH_TAB);

    w_cont   = in_word_r && alnum;
    emit_old = in_word_r && !alnum;
    start    = !in_word_r && letter;
    // a digit outside a word is an unknown byte
    single   = !space && !w_cont && !start;
    emit_eot = end_of_text && (w_cont || start);
    emit_word = emit_old || emit_eot;

    // word state after this byte, before any end-of-text clear
    in_word_nxt = w_cont || start;
    prefix_nxt  = prefix_r;
    len_nxt     = len_r;
    wline_nxt   = wline_r;
    wcol_nxt    = wcol_r;
    woff_nxt    = woff_r;
    if (w_cont) begin
      for (int i = 0; i < PREFIX_CHARS; i++) begin
        if ((len_r < 8'(PREFIX_CHARS)) && (len_r[2:0] == 3'(i)))
          prefix_nxt[8*i +: 8] = char_code;
      end
      len_nxt = (len_r == 8'hFF) ? len_r : len_r + 8'd1;
    end else if (start) begin
      prefix_nxt = {{(8*PREFIX_CHARS-8){1'b0}}, char_code};
      len_nxt    = 8'd1;
      wline_nxt  = line_r;
      wcol_nxt   = col_r;
      woff_nxt   = off_r;
    end

    if (char_code == CH_NEWLINE) begin
      line_nxt = (line_r == 32'hFFFF_FFFF) ? line_r : line_r + 32'd1;
      col_nxt  = 16'd1;
    end else begin
      line_nxt = line_r;
      col_nxt  = (col_r == 16'hFFFF) ? col_r : col_r + 16'd1;
    end
    off_nxt = (off_r == 32'hFFFF_FFFF) ? off_r : off_r + 32'd1;

    // the old word closes on a non-alnum byte; at end of text the updated word closes
    word_tok.kind     = (emit_old ? is_reserved(prefix_r, len_r)
                                  : is_reserved(prefix_nxt, len_nxt))
                        ? KIND_RESERVED : KIND_IDENT;
    word_tok.bad_char = 8'd0;
    word_tok.line     = emit_old ? wline_r : wline_nxt;
    word_tok.column   = emit_old ? wcol_r : wcol_nxt;
    word_tok.offset   = emit_old ? woff_r : woff_nxt;
    word_tok.length   = emit_old ? len_r : len_nxt;
    word_tok.last     = 1'b0;

    pkind             = punct_kind(char_code);
    char_tok.kind     = pkind;
    char_tok.bad_char = (pkind == KIND_UNKNOWN) ? char_code : 8'd0;
    char_tok.line     = line_r;
    char_tok.column   = col_r;
    char_tok.offset   = off_r;
    char_tok.length   = 8'd1;
    char_tok.last     = 1'b1;

    res.cnt         = step ? (2'(emit_word) + 2'(single)) : 2'd0;
    res.first       = emit_word ? word_tok : char_tok;
    res.first.last  = !(emit_word && single);
    res.second      = char_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_text)) begin
      in_word_r <= 1'b0;
      prefix_r  <= '0;
      len_r     <= 8'd0;
      wline_r   <= 32'd1;
      wcol_r    <= 16'd1;
      woff_r    <= 32'd0;
      line_r    <= 32'd1;
      col_r     <= 16'd1;
      off_r     <= 32'd0;
    end else if (step) begin
      in_word_r <= in_word_nxt;
      prefix_r  <= prefix_nxt;
      len_r     <= len_nxt;
      wline_r   <= wline_nxt;
      wcol_r    <= wcol_nxt;
      woff_r    <= woff_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      off_r     <= off_nxt;
    end
  end

  a_word_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    in_word_r |-> (len_r != 8'd0))
    else $error("open word with zero length");

  a_no_token_on_space: assert property (@(posedge clk) disable iff (!rst_n)
    (step && space && !in_word_r) |-> (res.cnt == 2'd0))
    else $error("whitespace produced a token");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && end_of_text) |=> (!in_word_r && (line_r == 32'd1) && (off_r == 32'd0)))
    else $error("state not cleared after end of text");

endmodule

>>> hdl/stt_fifo.sv
// Result queue: takes up to two tokens per cycle, hands out one word per cycle while out_stall is low.
module stt_fifo import stt_pkg::*; #(
  parameter int DEPTH = STT_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  res_pair_t push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output token_t    out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_inc;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    out_valid  = (count_r != '0);
    out_data   = mem_r[rd_ptr_r];
    pop        = out_valid && !out_stall;
    // hold off input until two free slots are certain
    full       = (count_r > CNT_W'(DEPTH - 2));
    wr_ptr_inc = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = (push.cnt == 2'd2) ? ptr_inc(wr_ptr_inc)
               : (push.cnt == 2'd1) ? wr_ptr_inc : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.first;
    if (push.cnt == 2'd2) mem_r[wr_ptr_inc] <= push.second;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> !full)
    else $error("push into result queue without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (push.cnt == 2'd0)) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("result queue count did not drop on pop");

endmodule

>>> bench/source_text_tokenizer_test.sv
// Self-checking testbench for the source text tokenizer: byte stream in, token words out.

localparam string PUNCT_TEXT = "(){}[];,.-+/*!=<>\"";

class token_scoreboard;
  stt_pkg::token_t expected_tokens[$];
  int mismatches;

  bit          in_word;
  logic [63:0] word_prefix;
  logic [7:0]  word_len;
  logic [31:0] word_line;
  logic [15:0] word_column;
  logic [31:0] word_offset;
  logic [31:0] line_count;
  logic [15:0] column_count;
  logic [31:0] byte_offset;

  function new();
    mismatches = 0;
    restart_text();
  endfunction

  function void restart_text();
    in_word      = 1'b0;
    word_prefix  = '0;
    word_len     = '0;
    word_line    = 32'd1;
    word_column  = 16'd1;
    word_offset  = '0;
    line_count   = 32'd1;
    column_count = 16'd1;
    byte_offset  = '0;
  endfunction

  // pack a keyword the way the prefix is stored: first character in the low byte
  function logic [63:0] pack_text(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function void push_token(logic [4:0] kind, logic [7:0] bad, logic [31:0] line,
                           logic [15:0] column, logic [31:0] offset, logic [7:0] len);
    stt_pkg::token_t t;
    t.kind     = kind;
    t.bad_char = bad;
    t.line     = line;
    t.column   = column;
    t.offset   = offset;
    t.length   = len;
    t.last     = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function void close_word();
    bit reserved;
    reserved = (word_len == 8'd8 && word_prefix == pack_text("function")) ||
               (word_len == 8'd3 && word_prefix == pack_text("ret")) ||
               (word_len == 8'd3 && word_prefix == pack_text("i64"));
    push_token(reserved ? stt_pkg::KIND_RESERVED : stt_pkg::KIND_IDENT, 8'd0,
               word_line, word_column, word_offset, word_len);
    in_word = 1'b0;
  endfunction

  function void note_byte(logic [7:0] c, logic eot);
    bit letter, digit, white;
    int before_count;
    logic [4:0] kind;
    stt_pkg::token_t t;
    letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    digit  = (c >= "0" && c <= "9");
    white  = (c == stt_pkg::CH_NEWLINE) || (c == stt_pkg::CH_SPACE) ||
             (c == stt_pkg::CH_RETURN) || (c == stt_pkg::CH_TAB);
    before_count = expected_tokens.size();

    if (in_word && (letter || digit)) begin
      if (word_len < 8'd8) word_prefix[8*word_len +: 8] = c;
      if (word_len != 8'd255) word_len++;
    end else begin
      if (in_word) close_word();
      if (white) begin
        // no token
      end else if (letter) begin
        in_word     = 1'b1;
        word_prefix = {56'd0, c};
        word_len    = 8'd1;
        word_line   = line_count;
        word_column = column_count;
        word_offset = byte_offset;
      end else begin
        kind = stt_pkg::KIND_UNKNOWN;
        for (int i = 0; i < PUNCT_TEXT.len(); i++)
          if (PUNCT_TEXT[i] == c) kind = stt_pkg::KIND_PUNCT_BASE + 5'(i);
        push_token(kind, kind == stt_pkg::KIND_UNKNOWN ? c : 8'd0,
                   line_count, column_count, byte_offset, 8'd1);
      end
    end

    if (c == stt_pkg::CH_NEWLINE) begin
      if (line_count != 32'hFFFF_FFFF) line_count++;
      column_count = 16'd1;
    end else if (column_count != 16'hFFFF) begin
      column_count++;
    end
    if (byte_offset != 32'hFFFF_FFFF) byte_offset++;

    if (eot) begin
      if (in_word) close_word();
      restart_text();
    end

    // flag the final word caused by this byte
    if (expected_tokens.size() > before_count) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endfunction

  function void check_token(stt_pkg::token_t got);
    stt_pkg::token_t exp;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected token word: kind %0d line %0d col %0d off %0d len %0d",
                 got.kind, got.line, got.column, got.offset, got.length);
      return;
    end
    exp = expected_tokens.pop_front();
    if (got.kind !== exp.kind || got.bad_char !== exp.bad_char ||
        got.line !== exp.line || got.column !== exp.column ||
        got.offset !== exp.offset || got.length !== exp.length ||
        got.last !== exp.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display({"token mismatch expected: kind %0d bad %0h line %0d col %0d",
                  " off %0d len %0d last %0b"},
                 exp.kind, exp.bad_char, exp.line, exp.column, exp.offset, exp.length,
                 exp.last);
        $display({"               actual:   kind %0d bad %0h line %0d col %0d",
                  " off %0d len %0d last %0b"},
                 got.kind, got.bad_char, got.line, got.column, got.offset, got.length,
                 got.last);
      end
    end
  endfunction

  function int pending();
    return expected_tokens.size();
  endfunction
endclass

module source_text_tokenizer_test;
  import stt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_token_kind;
  logic [7:0]  out_bad_char;
  logic [31:0] out_token_line;
  logic [15:0] out_token_column;
  logic [31:0] out_token_offset;
  logic [7:0]  out_token_length;
  logic        out_last_of_run;

  token_scoreboard sb;
  int  cycle_count = 0;
  int  items_sent = 0;
  bit  idle_on = 1'b1;
  bit  stall_on = 1'b1;
  int  stall_left = 0;
  int  stall_pick;

  string trial_words[12] = '{"function", "ret", "i64", "functions", "functio", "re",
                             "i6", "i641", "Ret", "retx", "funct1on", "I64"};

  source_text_tokenizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_code(in_char_code), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_bad_char(out_bad_char),
    .out_token_line(out_token_line), .out_token_column(out_token_column),
    .out_token_offset(out_token_offset), .out_token_length(out_token_length),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("source_text_tokenizer test failed");
      $finish;
    end
  end

  // receiver back-pressure: mostly short stalls, a few long ones
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_on) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) stall_left = 0;
      else if (stall_pick < 92) stall_left = $urandom_range(1, 3);
      else stall_left = $urandom_range(10, 40);
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    stt_pkg::token_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind     = out_token_kind;
      got.bad_char = out_bad_char;
      got.line     = out_token_line;
      got.column   = out_token_column;
      got.offset   = out_token_offset;
      got.length   = out_token_length;
      got.last     = out_last_of_run;
      sb.check_token(got);
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    int r;
    gap = 0;
    if (idle_on) begin
      r = $urandom_range(0, 99);
      if (r < 50) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_char_code   = c;
    in_end_of_text = eot;
    do @(posedge clk); while (in_stall);
    sb.note_byte(c, eot);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] random_letter();
    int k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
  endfunction

  // letter first, then letters and digits
  task automatic send_word(input int len, input bit eot_last);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      if (i == 0 || $urandom_range(0, 3) != 0) c = random_letter();
      else c = 8'("0" + $urandom_range(0, 9));
      send_byte(c, eot_last && (i == len - 1));
    end
  endtask

  initial begin
    bit eot;
    int pick;
    sb = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_code   = 8'd0;
    in_end_of_text = 1'b0;
    out_stall      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: keywords, byte extremes, stray digit, whitespace, word closed by end of text
    send_text("function(ret)", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte("7", 1'b0);
    send_text("\t\r\n", 1'b0);
    send_text("Ab9", 1'b1);
    send_text("i6", 1'b0);
    send_byte("4", 1'b1);

    while (items_sent < 720) begin
      if ($urandom_range(0, 99) < 3) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      eot  = ($urandom_range(0, 99) < 6);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_word(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8),
                  eot);
      end else if (pick < 45) begin
        send_text(trial_words[$urandom_range(0, 11)], eot);
      end else if (pick < 65) begin
        send_byte(PUNCT_TEXT[$urandom_range(0, PUNCT_TEXT.len() - 1)], eot);
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: send_byte(CH_SPACE, eot);
          1: send_byte(CH_TAB, eot);
          2: send_byte(CH_RETURN, eot);
          default: send_byte(CH_NEWLINE, eot);
        endcase
      end else begin
        send_byte(8'($urandom_range(0, 255)), eot);
      end
    end

    // word length saturation, at and past the limit
    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_word(255, 1'b0);
    send_byte(";", 1'b0);
    send_word(300, 1'b0);
    send_byte(")", 1'b1);

    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("source_text_tokenizer test passed");
    end else begin
      $display("source_text_tokenizer test failed");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/stt_pkg.sv
hdl/stt_lex.sv
hdl/stt_fifo.sv
hdl/source_text_tokenizer.sv
bench/source_text_tokenizer_test.sv
